>>> design/owm_pkg.sv
// owm_pkg: shared types, constants and the quarter-wave sine table
// for the three-wheel omni mixer; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package owm_pkg;

   localparam int TRIG_FRACTION_BITS_DEF = 14;
   localparam int DRIVE_WIDTH_DEF        = 16;
   localparam int CMD_W                  = 13;
   localparam int HEAD_W                 = 16;
   localparam int LIMIT_W                = 15;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd255;
   localparam int FULL_TURN    = 5760;
   localparam int QUARTER_TURN = 1440;
   localparam int STEP_60      = 960;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SIN,
      ST_MUL_X,
      ST_MUL_Y,
      ST_SUM,
      ST_MAX,
      ST_DIV,
      ST_DONE
   } state_type;

   // quarter-wave sine in Q1.14 at one-degree steps
   function automatic logic [14:0] quarter_sine(input logic [6:0] k);
      logic [14:0] v;
      case (k)
         7'd0: v = 15'd0;      7'd1: v = 15'd286;    7'd2: v = 15'd572;
         7'd3: v = 15'd857;    7'd4: v = 15'd1143;   7'd5: v = 15'd1428;
         7'd6: v = 15'd1713;   7'd7: v = 15'd1997;   7'd8: v = 15'd2280;
         7'd9: v = 15'd2563;   7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
         7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
         7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
         7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
         7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
         7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
         7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
         7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
         7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
         7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
         7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
         7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
         7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
         7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
         7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
         7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
         7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
         7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
         7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
         7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
         7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
         7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
         7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
         7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
         7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
         7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
         7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
         default: v = 15'd16384;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> design/omni3_wheel_mixer_heading_hold.sv
// omni3_wheel_mixer_heading_hold: top level, sequencer, shared multiplier
// depends on owm_pkg, owm_sine, owm_divider
//
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_move_x, req_move_y, req_turn_cmd,
//          |           | req_heading
//  rsp     | out       | rsp_valid, rsp_stall, rsp_wheel_a..c, rsp_limited
//  csr     | in        | csr_write, csr_drive_limit
//
// An item is accepted in the idle state; each wheel then passes through the sine
// lookup, two multiplies on the shared multiplier and the sum, and the result is
// offered in the done state; the next item is accepted once it has been taken.
// When scaling applies the bit-serial divider scales each wheel in turn, with a
// DRIVE_WIDTH+LIMIT_W bit quotient, between the max and the done states.
// Synchronous reset clears the sequencer, drive_limit to 255 and the reference.
// req_stall is high from accept until the result has been taken on rsp.
`timescale 1ns / 1ps
`default_nettype none
module omni3_wheel_mixer_heading_hold import owm_pkg::*; #(
   parameter int TRIG_FRACTION_BITS = TRIG_FRACTION_BITS_DEF,
   parameter int DRIVE_WIDTH        = DRIVE_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [CMD_W-1:0] req_move_x,
   input  wire logic signed [CMD_W-1:0] req_move_y,
   input  wire logic signed [CMD_W-1:0] req_turn_cmd,
   input  wire logic signed [HEAD_W-1:0] req_heading,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [DRIVE_WIDTH-1:0] rsp_wheel_a,
   output logic signed [DRIVE_WIDTH-1:0] rsp_wheel_b,
   output logic signed [DRIVE_WIDTH-1:0] rsp_wheel_c,
   output logic                         rsp_limited,
   input  wire logic                    csr_write,
   input  wire logic [LIMIT_W-1:0]      csr_drive_limit
);
   localparam int SW  = TRIG_FRACTION_BITS + 2;
   localparam int PW  = SW + CMD_W;          // one product
   localparam int FB  = TRIG_FRACTION_BITS + 4;
   localparam int AW  = FB + 24;             // accumulator in Q(F+4)
   localparam int DW  = DRIVE_WIDTH;
   localparam int NW  = DW + LIMIT_W;        // |w|*limit
   localparam logic signed [AW-1:0] SATHI = (AW'(1) <<< (DW - 1)) - AW'(1);
   localparam logic signed [AW-1:0] SATLO = -(AW'(1) <<< (DW - 1));

   state_type state_ff, state_in;

   logic [LIMIT_W-1:0]      limit_ff;
   logic signed [HEAD_W-1:0] ref_ff;
   logic signed [CMD_W-1:0] x_ff, y_ff;
   logic [12:0]             hmod_ff;
   logic signed [AW-1:0]    rot_ff;
   logic [1:0]              wi_ff, wi_in;
   logic                    phase_ff, phase_in;   // 0: cosine, 1: sine
   logic signed [AW-1:0]    proj_ff;
   logic signed [DW-1:0]    w_ff [3];
   logic [DW-1:0]           big_ff;
   logic                    lim_ff;
   logic                    rsp_valid_ff;

   logic [15:0]        hu;
   logic [8:0]         ht;
   logic [19:0]        hq_prod;
   logic [3:0]         hq;
   logic [5:0]         hr;
   logic [12:0]        hum;
   logic [12:0]        hmod_in;
   logic [13:0]        ang_sum;
   logic [12:0]        angle;
   logic signed [SW-1:0] sine;
   logic signed [CMD_W-1:0] mul_a;
   logic signed [SW-1:0]   mul_b;
   logic signed [PW-1:0]   prod;
   logic signed [AW-1:0]   acc, quo;
   logic signed [AW-1:0]   wsat;
   logic signed [DW-1:0]   cur_w;
   logic [DW-1:0]          mag_w;
   logic [NW-1:0]          numer;
   logic                   over_limit;
   logic                   div_start, div_busy;
   logic [NW-1:0]          div_q;
   logic signed [HEAD_W:0] dh;
   logic signed [AW-1:0]   rot_in;

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_wheel_a = w_ff[0];
   assign rsp_wheel_b = w_ff[1];
   assign rsp_wheel_c = w_ff[2];
   assign rsp_limited = lim_ff;

   // heading modulo one turn: bias to unsigned, split off 128-unit blocks,
   // reduce the block count mod 45 by reciprocal multiply, then remove the bias
   always_comb begin
      hu      = {~req_heading[HEAD_W-1], req_heading[HEAD_W-2:0]};
      ht      = hu[15:7];
      hq_prod = 20'(ht) * 20'd1457;
      hq      = hq_prod[19:16];
      hr      = 6'(ht - 9'(hq) * 9'd45);
      hum     = {hr, hu[6:0]};
      hmod_in = (hum >= 13'd3968) ? 13'(hum - 13'd3968) : 13'(hum + 13'd1792);
   end

   // wheel angle, cosine is sine shifted by a quarter turn, wrapped to one turn
   always_comb begin
      ang_sum = 14'(hmod_ff) + 14'(wi_ff) * 14'(STEP_60)
              + (phase_ff ? 14'd0 : 14'(QUARTER_TURN));
      angle   = (ang_sum >= 14'(FULL_TURN)) ? 13'(ang_sum - 14'(FULL_TURN))
                                             : 13'(ang_sum);
   end

   owm_sine #(.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_sine (
      .clock(clock), .angle(angle), .sine_ff(sine)
   );

   // shared multiplier: command times trig value, cosine arrives in MUL_X
   assign mul_a = (state_ff == ST_MUL_Y) ? y_ff : x_ff;
   assign mul_b = sine;
   assign prod  = PW'(mul_a) * PW'(mul_b);

   // wheel sum, truncation toward zero and saturation
   always_comb begin
      acc = ((wi_ff == 2'd1) ? proj_ff : -proj_ff) * AW'(16) - rot_ff;
      quo = (acc < 0) ? -((-acc) >>> FB) : (acc >>> FB);
      if (quo > SATHI) wsat = SATHI;
      else if (quo < SATLO) wsat = SATLO;
      else wsat = quo;
   end

   // rotation term
   always_comb begin
      dh = (HEAD_W + 1)'(req_heading) - (HEAD_W + 1)'(ref_ff);
      if (req_turn_cmd != '0)
         rot_in = AW'(req_turn_cmd) <<< FB;
      else if (dh > -(HEAD_W + 1)'(8) && dh < (HEAD_W + 1)'(8))
         rot_in = '0;
      else
         rot_in = (AW'(dh) * AW'(7)) <<< TRIG_FRACTION_BITS;
   end

   // scaling divider operands
   assign cur_w      = w_ff[wi_ff];
   assign mag_w      = cur_w[DW-1] ? DW'(-cur_w) : DW'(cur_w);
   assign numer      = NW'(mag_w) * NW'(limit_ff);
   assign over_limit = (NW'(big_ff) > NW'(limit_ff));
   assign div_start  = (state_ff == ST_MAX && over_limit)
                       || (state_ff == ST_DIV && !phase_ff);

   owm_divider #(.NUM_W(NW), .DEN_W(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(numer), .denom(big_ff), .busy_ff(div_busy), .quot_ff(div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SIN;
         ST_SIN:   state_in = ST_MUL_X;
         ST_MUL_X: state_in = ST_MUL_Y;
         ST_MUL_Y: state_in = ST_SUM;
         ST_SUM:   state_in = (wi_ff == 2'd2) ? ST_MAX : ST_SIN;
         ST_MAX:   state_in = over_limit ? ST_DIV : ST_DONE;
         ST_DIV:   if (!div_busy && phase_ff && wi_ff == 2'd2) state_in = ST_DONE;
         ST_DONE:  if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // wheel index and phase sequencing; in DIV phase 0 starts a wheel, 1 waits
   always_comb begin
      wi_in    = wi_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE:  begin wi_in = 2'd0; phase_in = 1'b0; end
         ST_SIN:   phase_in = 1'b1;      // cosine lookup issued, fetch sine
         ST_MUL_Y: phase_in = 1'b0;
         ST_SUM:   wi_in = (wi_ff == 2'd2) ? 2'd0 : wi_ff + 2'd1;
         ST_MAX:   begin wi_in = 2'd0; phase_in = 1'b1; end
         ST_DIV: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else if (!div_busy && wi_ff != 2'd2) begin
               wi_in    = wi_ff + 2'd1;
               phase_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         ref_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         wi_ff        <= 2'd0;
         phase_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         wi_ff    <= wi_in;
         phase_ff <= phase_in;
         if (csr_write) limit_ff <= csr_drive_limit;
         if (state_ff == ST_IDLE && req_valid && req_turn_cmd != '0)
            ref_ff <= req_heading;
         rsp_valid_ff <= (state_in == ST_DONE);
      end
      // payload
      case (state_ff)
         ST_IDLE: begin
            x_ff <= req_move_x; y_ff <= req_move_y; hmod_ff <= hmod_in;
            rot_ff <= rot_in; big_ff <= '0; lim_ff <= 1'b0;
         end
         ST_MUL_X: proj_ff <= AW'(prod);
         ST_MUL_Y: proj_ff <= proj_ff + AW'(prod);
         ST_SUM: begin
            w_ff[wi_ff] <= DW'(wsat);
            if (((wsat < 0) ? DW'(-wsat) : DW'(wsat)) > big_ff && wsat != SATLO)
               big_ff <= (wsat < 0) ? DW'(-wsat) : DW'(wsat);
            else if (wsat == SATLO)
               big_ff <= DW'(1) << (DW - 1);
         end
         ST_MAX: if (over_limit) lim_ff <= 1'b1;
         ST_DIV: if (!div_busy && phase_ff)
                    w_ff[wi_ff] <= cur_w[DW-1] ? -DW'(div_q) : DW'(div_q);
         default: ;
      endcase
   end
endmodule
`default_nettype wire

>>> design/owm_sine.sv
// owm_sine: registered sine lookup with linear interpolation, Q1.F output
// depends on owm_pkg
`timescale 1ns / 1ps
`default_nettype none
module owm_sine import owm_pkg::*; #(
   parameter int TRIG_FRACTION_BITS = TRIG_FRACTION_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic [12:0]                   angle,   // 0..5759
   output logic signed [TRIG_FRACTION_BITS+1:0] sine_ff
);
   localparam int SW = TRIG_FRACTION_BITS + 2;

   logic [1:0]  quad;
   logic [10:0] rem;
   logic [10:0] u;
   logic [6:0]  k;
   logic [3:0]  frac;
   logic [14:0] s0, s1;
   logic [19:0] ip;
   logic [14:0] mag;
   logic [SW-1:0] scaled;
   logic signed [SW-1:0] sine_in;

   // quadrant split and table interpolation
   always_comb begin
      if (angle >= 13'(3 * QUARTER_TURN)) begin
         quad = 2'd3; rem = 11'(angle - 13'(3 * QUARTER_TURN));
      end else if (angle >= 13'(2 * QUARTER_TURN)) begin
         quad = 2'd2; rem = 11'(angle - 13'(2 * QUARTER_TURN));
      end else if (angle >= 13'(QUARTER_TURN)) begin
         quad = 2'd1; rem = 11'(angle - 13'(QUARTER_TURN));
      end else begin
         quad = 2'd0; rem = 11'(angle);
      end
      u    = quad[0] ? 11'(11'(QUARTER_TURN) - rem) : rem;
      k    = 7'(u >> 4);
      frac = u[3:0];
      s0   = quarter_sine(k);
      s1   = quarter_sine(7'(k + 7'd1));
      ip   = 20'(s1 - s0) * 20'(frac);
      mag  = (k >= 7'd90) ? s0 : 15'(s0 + 15'(ip >> 4));
      if (TRIG_FRACTION_BITS >= 14)
         scaled = SW'(mag) << (TRIG_FRACTION_BITS - 14);
      else
         scaled = SW'((16'(mag) + (16'd1 << (13 - TRIG_FRACTION_BITS)))
                      >> (14 - TRIG_FRACTION_BITS));
      sine_in = quad[1] ? -$signed(scaled) : $signed(scaled);
   end

   always_ff @(posedge clock) begin
      sine_ff <= sine_in;
   end
endmodule
`default_nettype wire

>>> design/owm_divider.sv
// owm_divider: restoring divider, one quotient bit per cycle, unsigned
// depends on owm_pkg
`timescale 1ns / 1ps
`default_nettype none
module owm_divider import owm_pkg::*; #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  busy_ff,
   output logic [NUM_W-1:0]      quot_ff
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [DEN_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] quot_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_in;
   logic [DEN_W:0]   trial;

   // shift in one numerator bit, subtract when it fits
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = '0;
      if (start) begin
         rem_in  = '0;
         quot_in = numer;
         cnt_in  = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[DEN_W-1:0], quot_ff[NUM_W-1]};
         if (trial >= {1'b0, denom}) begin
            rem_in  = trial - {1'b0, denom};
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end
endmodule
`default_nettype wire

>>> dv/omni3_wheel_mixer_heading_hold_tb.sv
// omni3_wheel_mixer_heading_hold_tb: self-checking bench for the omni wheel mixer
// depends on owm_pkg and omni3_wheel_mixer_heading_hold
`timescale 1ns / 1ps
module omni3_wheel_mixer_heading_hold_tb;
   import owm_pkg::*;

   localparam int FRAC  = TRIG_FRACTION_BITS_DEF;
   localparam int DRV_W = DRIVE_WIDTH_DEF;

   typedef struct packed {
      logic signed [DRV_W-1:0] a;
      logic signed [DRV_W-1:0] b;
      logic signed [DRV_W-1:0] c;
      logic                    lim;
   } wheels_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CMD_W-1:0] req_move_x = '0, req_move_y = '0, req_turn_cmd = '0;
   logic signed [HEAD_W-1:0] req_heading = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DRV_W-1:0] rsp_wheel_a, rsp_wheel_b, rsp_wheel_c;
   logic rsp_limited;
   logic csr_write = 1'b0;
   logic [LIMIT_W-1:0] csr_drive_limit = '0;

   // predictor state
   logic [LIMIT_W-1:0] model_limit;
   longint model_ref;
   wheels_type drive_expect_q[$];
   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   omni3_wheel_mixer_heading_hold dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_move_x(req_move_x), .req_move_y(req_move_y),
      .req_turn_cmd(req_turn_cmd), .req_heading(req_heading),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_wheel_a(rsp_wheel_a), .rsp_wheel_b(rsp_wheel_b),
      .rsp_wheel_c(rsp_wheel_c), .rsp_limited(rsp_limited),
      .csr_write(csr_write), .csr_drive_limit(csr_drive_limit)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // interpolated quarter-wave sine in Q1.14
   function automatic longint quarter_q14(input int u);
      int k;
      int f;
      longint lo;
      longint hi;
      k = u >> 4;
      f = u & 15;
      if (k >= 90) return longint'(quarter_sine(7'd90));
      lo = longint'(quarter_sine(k[6:0]));
      hi = longint'(quarter_sine(7'(k + 1)));
      return lo + (((hi - lo) * f) >>> 4);
   endfunction

   // sine at Q1.FRAC for any angle in 1/16 degree
   function automatic longint sine_at(input int ang);
      int m;
      int q;
      int r;
      longint mag;
      m = ang % FULL_TURN;
      if (m < 0) m += FULL_TURN;
      q = m / QUARTER_TURN;
      r = m % QUARTER_TURN;
      mag = (q & 1) ? quarter_q14(QUARTER_TURN - r) : quarter_q14(r);
      if (FRAC >= 14) mag = mag <<< (FRAC - 14);
      else mag = (mag + (1 << (13 - FRAC))) >>> (14 - FRAC);
      return (q >= 2) ? -mag : mag;
   endfunction

   function automatic longint clamp_drive(input longint v);
      longint hi;
      hi = (longint'(1) <<< (DRV_W - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // expected wheel drives for one item, updates the heading reference
   function automatic wheels_type mix_wheels(input longint x, input longint y,
                                             input longint turn, input longint head);
      longint unity;
      longint rot;
      longint d;
      longint proj;
      longint w[3];
      longint largest;
      longint mag;
      wheels_type r;
      unity = longint'(1) <<< (FRAC + 4);
      largest = 0;
      if (turn != 0) begin
         model_ref = head;
         rot = turn * unity;
      end else begin
         d = head - model_ref;
         rot = (d > -8 && d < 8) ? 0 : d * 7 * (longint'(1) <<< FRAC);
      end
      for (int i = 0; i < 3; i++) begin
         proj = x * sine_at(int'(head) + i * STEP_60 + QUARTER_TURN)
              + y * sine_at(int'(head) + i * STEP_60);
         if (i != 1) proj = -proj;
         w[i] = clamp_drive((proj * 16 - rot) / unity);
         mag = w[i] < 0 ? -w[i] : w[i];
         if (mag > largest) largest = mag;
      end
      r.lim = 1'b0;
      if (longint'(model_limit) < largest) begin
         r.lim = 1'b1;
         for (int i = 0; i < 3; i++) w[i] = (w[i] * longint'(model_limit)) / largest;
      end
      r.a = w[0][DRV_W-1:0];
      r.b = w[1][DRV_W-1:0];
      r.c = w[2][DRV_W-1:0];
      return r;
   endfunction

   // send one item and queue its expected drives
   task automatic send_item(input int x, input int y, input int turn, input int head);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_move_x   <= x[CMD_W-1:0];
      req_move_y   <= y[CMD_W-1:0];
      req_turn_cmd <= turn[CMD_W-1:0];
      req_heading  <= head[HEAD_W-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      drive_expect_q.push_back(mix_wheels(longint'(signed'(x[CMD_W-1:0])),
         longint'(signed'(y[CMD_W-1:0])), longint'(signed'(turn[CMD_W-1:0])),
         longint'(signed'(head[HEAD_W-1:0]))));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // write drive_limit while idle
   task automatic write_limit(input int value);
      drain();
      csr_write       <= 1'b1;
      csr_drive_limit <= value[LIMIT_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      model_limit = value[LIMIT_W-1:0];
   endtask

   // field extremes, both turn signs, hold dead zone edges
   task automatic test_directed;
      send_item(0, 0, 0, 0);
      send_item(4095, 0, 0, 0);
      send_item(-4096, 0, 0, 0);
      send_item(0, 4095, 0, 0);
      send_item(0, -4096, 0, 0);
      send_item(0, 0, 4095, 0);
      send_item(0, 0, -4096, 100);
      send_item(0, 0, 0, 107);
      send_item(0, 0, 0, 108);
      send_item(0, 0, 0, 93);
      send_item(0, 0, 0, 92);
      send_item(0, 0, 1, 32767);
      send_item(0, 0, 0, -32768);
      send_item(-4096, -4096, -4096, -32768);
      send_item(4095, 4095, 4095, 32767);
      send_item(1000, -1000, 0, 1440);
      send_item(-1, 1, 0, 5760);
   endtask

   task automatic test_limits;
      write_limit(32767);
      test_directed();
      write_limit(1);
      test_directed();
      write_limit(255);
   endtask

   // mostly hold items near the reference, some turns and wide headings
   task automatic test_random(input int count);
      int sel;
      int head;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(9);
         if (sel < 5) head = int'(model_ref) + $urandom_range(200) - 100;
         else head = $urandom_range(65535) - 32768;
         send_item($urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                   (sel < 7) ? 0 : $urandom_range(8191) - 4096, head);
      end
   endtask

   // random stall on the result side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // compare each accepted result against the oldest expectation
   always @(posedge clock) begin
      wheels_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_expect_q.size() == 0) begin
            $display("%0t: unexpected result a=%0d b=%0d c=%0d lim=%0b", $time,
                     rsp_wheel_a, rsp_wheel_b, rsp_wheel_c, rsp_limited);
            fail_count++;
         end else begin
            exp_w = drive_expect_q.pop_front();
            if (rsp_wheel_a !== exp_w.a) begin
               $display("%0t: wheel_a expected %0d actual %0d", $time, exp_w.a, rsp_wheel_a);
               fail_count++;
            end
            if (rsp_wheel_b !== exp_w.b) begin
               $display("%0t: wheel_b expected %0d actual %0d", $time, exp_w.b, rsp_wheel_b);
               fail_count++;
            end
            if (rsp_wheel_c !== exp_w.c) begin
               $display("%0t: wheel_c expected %0d actual %0d", $time, exp_w.c, rsp_wheel_c);
               fail_count++;
            end
            if (rsp_limited !== exp_w.lim) begin
               $display("%0t: limited expected %0b actual %0b", $time, exp_w.lim, rsp_limited);
               fail_count++;
            end
         end
      end
   end

   initial begin
      model_limit = LIMIT_RESET;
      model_ref = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 29;
      recv_idle_pct = 69;
      test_directed();
      test_limits();
      test_random(150);
      write_limit($urandom_range(32767, 1));
      send_idle_pct = 69;
      recv_idle_pct = 29;
      test_random(150);
      write_limit($urandom_range(4000, 1));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(130);
      drain();
      if (fail_count == 0)
         $display("omni3_wheel_mixer_heading_hold_tb: PASS");
      else
         $display("omni3_wheel_mixer_heading_hold_tb: FAIL");
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("omni3_wheel_mixer_heading_hold_tb: FAIL");
      $finish;
   end
endmodule
